// ===== rtl/sfpa_pkg.sv =====
// shared types and constants for the sensor frame parser
// no dependencies

package sfpa_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned AngleW = 24;
  localparam int unsigned NumData = 6;

  // first frame position holding angle data
  localparam logic [ByteW-1:0] DataFirstPos = 8'd16;

  // length byte values
  localparam logic [ByteW-1:0] MinLength    = 8'd4;
  localparam logic [ByteW-1:0] MinSumLength = 8'd6;

  // configuration register indexes
  localparam logic [2:0] REG_SYNC_FIRST  = 3'd0;
  localparam logic [2:0] REG_SYNC_SECOND = 3'd1;
  localparam logic [2:0] REG_TAIL_FIRST  = 3'd2;
  localparam logic [2:0] REG_TAIL_SECOND = 3'd3;
  localparam logic [2:0] REG_SENSOR_CMD  = 3'd4;

  // configuration reset values
  localparam logic [ByteW-1:0] RST_SYNC_FIRST  = 8'h12;
  localparam logic [ByteW-1:0] RST_SYNC_SECOND = 8'h34;
  localparam logic [ByteW-1:0] RST_TAIL_FIRST  = 8'h1F;
  localparam logic [ByteW-1:0] RST_TAIL_SECOND = 8'h2F;
  localparam logic [ByteW-1:0] RST_SENSOR_CMD  = 8'h01;

  typedef enum logic [1:0] {
    ST_SENSOR_OK  = 2'd0,
    ST_OTHER_OK   = 2'd1,
    ST_TRAILER_BAD = 2'd2,
    ST_CHECKSUM_BAD = 2'd3
  } status_e;

  typedef struct packed {
    logic [ByteW-1:0] sync_first;
    logic [ByteW-1:0] sync_second;
    logic [ByteW-1:0] tail_first;
    logic [ByteW-1:0] tail_second;
    logic [ByteW-1:0] sensor_cmd;
  } cfg_t;

  // one finished frame, handed from the parser to the angle stage
  typedef struct packed {
    status_e                      status;
    logic [NumData-1:0][ByteW-1:0] data;
  } frame_rec_t;

endpackage

// ===== rtl/sfpa_front.sv =====
// byte parser: sync hunt, length, running checksum, trailer check
// depends on sfpa_pkg

module sfpa_front import sfpa_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cfg_t             cfg_i,
  input  logic             accept_i,
  input  logic [ByteW-1:0] rx_byte_i,
  output logic             push_o,
  output frame_rec_t       rec_o
);

  logic [ByteW-1:0] pos_q, pos_d;
  logic [ByteW-1:0] hdr0_q, hdr0_d, hdr1_q, hdr1_d;
  logic [ByteW-1:0] len_q, len_d;
  logic [ByteW-1:0] sum_q, sum_d;
  logic [ByteW-1:0] cmd_q, cmd_d;
  logic [2:0][ByteW-1:0] rec_q, rec_d;
  logic [NumData-1:0][ByteW-1:0] data_q, data_d;

  logic [NumData-1:0][ByteW-1:0] data_n;
  logic [ByteW-1:0] sum_n, cmd_n;
  logic [ByteW:0]   pos_next;
  logic             hdr_match;

  always_comb begin
    pos_d  = pos_q;
    hdr0_d = hdr0_q;
    hdr1_d = hdr1_q;
    len_d  = len_q;
    sum_d  = sum_q;
    cmd_d  = cmd_q;
    rec_d  = rec_q;
    data_d = data_q;
    push_o = 1'b0;
    rec_o  = '{status: ST_SENSOR_OK, data: data_q};

    hdr_match = (hdr0_q == cfg_i.sync_first) && (hdr1_q == cfg_i.sync_second) &&
                (rx_byte_i >= MinLength);
    cmd_n    = (pos_q == 8'd3) ? rx_byte_i : cmd_q;
    data_n   = data_q;
    for (int i = 0; i < NumData; i++) begin
      if (pos_q == DataFirstPos + ByteW'(i)) data_n[i] = rx_byte_i;
    end
    sum_n    = (({1'b0, pos_q} + 9'd4) <= {1'b0, len_q}) ? sum_q + rx_byte_i : sum_q;
    pos_next = {1'b0, pos_q} + 9'd1;

    if (accept_i) begin
      rec_d = {rx_byte_i, rec_q[2], rec_q[1]};
      if (pos_q < 8'd2) begin
        if (pos_q[0]) begin
          hdr1_d = rx_byte_i;
        end else begin
          hdr0_d = rx_byte_i;
        end
        pos_d = pos_q + 8'd1;
      end else if (pos_q == 8'd2) begin
        if (hdr_match) begin
          len_d = rx_byte_i;
          sum_d = (rx_byte_i >= MinSumLength) ? rx_byte_i : '0;
          pos_d = 8'd3;
        end else begin
          // slide by one byte
          hdr0_d = hdr1_q;
          hdr1_d = rx_byte_i;
        end
      end else if (pos_next < {1'b0, len_q}) begin
        pos_d  = pos_next[ByteW-1:0];
        sum_d  = sum_n;
        cmd_d  = cmd_n;
        data_d = data_n;
      end else begin
        // frame end: classify and clear
        push_o = 1'b1;
        if (rx_byte_i != cfg_i.tail_second || rec_q[2] != cfg_i.tail_first) begin
          rec_o.status = ST_TRAILER_BAD;
        end else if (rec_q[1] != sum_n) begin
          rec_o.status = ST_CHECKSUM_BAD;
        end else if (cmd_n == cfg_i.sensor_cmd) begin
          rec_o.status = ST_SENSOR_OK;
        end else begin
          rec_o.status = ST_OTHER_OK;
        end
        rec_o.data = data_n;
        pos_d  = '0;
        hdr0_d = '0;
        hdr1_d = '0;
        len_d  = '0;
        sum_d  = '0;
        cmd_d  = '0;
        data_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      hdr0_q <= '0;
      hdr1_q <= '0;
      len_q  <= '0;
      sum_q  <= '0;
      cmd_q  <= '0;
      rec_q  <= '0;
      data_q <= '0;
    end else begin
      pos_q  <= pos_d;
      hdr0_q <= hdr0_d;
      hdr1_q <= hdr1_d;
      len_q  <= len_d;
      sum_q  <= sum_d;
      cmd_q  <= cmd_d;
      rec_q  <= rec_d;
      data_q <= data_d;
    end
  end

endmodule

// ===== rtl/sfpa_fifo.sv =====
// small queue of finished frame records between parser and angle stage
// depends on sfpa_pkg

module sfpa_fifo import sfpa_pkg::*; #(
  parameter int unsigned Depth = 2
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  frame_rec_t wdata_i,
  output logic       full_o,
  output logic       valid_o,
  input  logic       pop_i,
  output frame_rec_t rdata_o
);

  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW  = $clog2(Depth + 1);

  frame_rec_t mem_q [Depth];
  logic [AddrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]  cnt_q;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign valid_o = (cnt_q != '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;
  assign rdata_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= wdata_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == AddrW'(Depth - 1)) ? '0 : wr_ptr_q + AddrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == AddrW'(Depth - 1)) ? '0 : rd_ptr_q + AddrW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

endmodule

// ===== rtl/sfpa_back.sv =====
// angle stage: scales the three raw values by 180 (zero unless the status is sensor OK) into the output register
// depends on sfpa_pkg

module sfpa_back import sfpa_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     rec_valid_i,
  input  frame_rec_t               rec_i,
  output logic                     pop_o,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic [1:0]               frame_status_o,
  output logic signed [AngleW-1:0] angle_x_o,
  output logic signed [AngleW-1:0] angle_y_o,
  output logic signed [AngleW-1:0] angle_z_o
);

  function automatic logic signed [AngleW-1:0] angle_of(logic [ByteW-1:0] lo,
                                                        logic [ByteW-1:0] hi,
                                                        logic             keep);
    logic signed [AngleW-1:0] raw;
    raw = AngleW'($signed({hi, lo}));
    return keep ? raw * 24'sd180 : '0;
  endfunction

  logic                     valid_q;
  logic [1:0]               status_q;
  logic signed [AngleW-1:0] ax_q, ay_q, az_q;
  logic                     keep;

  assign pop_o = rec_valid_i && (!valid_q || !out_stall_i);
  assign keep  = (rec_i.status == ST_SENSOR_OK);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (pop_o) begin
      valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      status_q <= rec_i.status;
      ax_q     <= angle_of(rec_i.data[0], rec_i.data[1], keep);
      ay_q     <= angle_of(rec_i.data[2], rec_i.data[3], keep);
      az_q     <= angle_of(rec_i.data[4], rec_i.data[5], keep);
    end
  end

  assign out_valid_o    = valid_q;
  assign frame_status_o = status_q;
  assign angle_x_o      = ax_q;
  assign angle_y_o      = ay_q;
  assign angle_z_o      = az_q;

endmodule

// ===== rtl/sensor_frame_parser_angle.sv =====
// sensor frame parser: one byte per beat in, one status/angle beat per frame out
// throughput: one byte per cycle; the parser only stalls when the record queue is full
// result path: a frame's record enters the queue at the edge that accepts its last byte,
//   then passes to the angle multiply output register, which out_stall_i can hold
// reset: asynchronous active low; clears parser position, queue and output valid,
//   and loads the default sync, trailer and sensor command bytes
// depends on sfpa_pkg, sfpa_front, sfpa_fifo, sfpa_back

module sensor_frame_parser_angle import sfpa_pkg::*; #(
  parameter int unsigned QueueDepth = 2
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // configuration write channel
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [2:0]               cfg_index_i,
  input  logic [ByteW-1:0]         cfg_data_i,
  // byte input channel
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [ByteW-1:0]         rx_byte_i,
  // result channel
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic [1:0]               frame_status_o,
  output logic signed [AngleW-1:0] angle_x_o,
  output logic signed [AngleW-1:0] angle_y_o,
  output logic signed [AngleW-1:0] angle_z_o
);

  cfg_t       cfg_q;
  logic       in_accept;
  logic       push, q_full, q_valid, q_pop;
  frame_rec_t push_rec, pop_rec;

  // config writes are always accepted and registered
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sync_first  <= RST_SYNC_FIRST;
      cfg_q.sync_second <= RST_SYNC_SECOND;
      cfg_q.tail_first  <= RST_TAIL_FIRST;
      cfg_q.tail_second <= RST_TAIL_SECOND;
      cfg_q.sensor_cmd  <= RST_SENSOR_CMD;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_SYNC_FIRST:  cfg_q.sync_first  <= cfg_data_i;
        REG_SYNC_SECOND: cfg_q.sync_second <= cfg_data_i;
        REG_TAIL_FIRST:  cfg_q.tail_first  <= cfg_data_i;
        REG_TAIL_SECOND: cfg_q.tail_second <= cfg_data_i;
        REG_SENSOR_CMD:  cfg_q.sensor_cmd  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // hold off input bytes only while the record queue has no room
  assign in_stall_o = q_full;
  assign in_accept  = in_valid_i && !q_full;

  // front: sync hunt, checksum and trailer classification
  sfpa_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .accept_i  (in_accept),
    .rx_byte_i (rx_byte_i),
    .push_o    (push),
    .rec_o     (push_rec)
  );

  // decouples parsing from a stalled result consumer
  sfpa_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (push_rec),
    .full_o  (q_full),
    .valid_o (q_valid),
    .pop_i   (q_pop),
    .rdata_o (pop_rec)
  );

  // back: angle scaling and output register
  sfpa_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .rec_valid_i    (q_valid),
    .rec_i          (pop_rec),
    .pop_o          (q_pop),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .frame_status_o (frame_status_o),
    .angle_x_o      (angle_x_o),
    .angle_y_o      (angle_y_o),
    .angle_z_o      (angle_z_o)
  );

endmodule
